FILE: rtl/core/modexp_pkg.sv
// Shared types and constants for the modular exponentiation core.
package modexp_pkg;

  localparam int WIDE_BITS = 63;
  localparam int CNT_W     = $clog2(WIDE_BITS + 1);

  typedef enum logic [1:0] {
    OP_REDUCE = 2'd0,
    OP_MUL    = 2'd1,
    OP_SQR    = 2'd2
  } op_t;

  typedef struct packed {
    logic load;
    logic op_start;
    op_t  op;
    logic wr_base;
    logic wr_acc;
    logic shift_exp;
    logic emit;
  } mx_cmd_t;

  typedef struct packed {
    logic op_done;
    logic exp_zero;
    logic exp_lsb;
    logic exp_last;
  } mx_status_t;

endpackage

FILE: rtl/core/modular_exponentiation_core.sv
// Top level: base^exponent mod modulus by right-to-left square-and-multiply.
//
//   Channel  Handshake          Payload
//   input    start & !busy      in_base_value, in_exponent, in_modulus
//   result   out_valid (1 clk)  out_power_result
//
// One transaction: the base is first reduced mod the modulus; then each exponent bit
// takes a multiply if set and a square (skipped after the last set bit), all in the
// single bit-serial multiply/reduce unit (one multiplier bit per cycle).
// Synchronous active-low reset returns the sequencer to idle; no pending result.
// busy stays high until the result strobe; the receiver cannot stall.
module modular_exponentiation_core #(
  parameter int MOD_BITS = 31
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [modexp_pkg::WIDE_BITS-1:0] in_base_value,
  input  logic [modexp_pkg::WIDE_BITS-1:0] in_exponent,
  input  logic [MOD_BITS-1:0]              in_modulus,
  output logic                             out_valid,
  output logic [MOD_BITS-1:0]              out_power_result
);
  import modexp_pkg::*;

  mx_cmd_t    cmd;
  mx_status_t status;

  modexp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd),
    .status    (status)
  );

  modexp_datapath #(
    .MOD_BITS (MOD_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .in_base_value    (in_base_value),
    .in_exponent      (in_exponent),
    .in_modulus       (in_modulus),
    .out_power_result (out_power_result)
  );

endmodule

FILE: rtl/core/modexp_datapath.sv
// Operand registers and the shared bit-serial modular multiply/reduce unit.
module modexp_datapath #(
  parameter int MOD_BITS = 31
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  modexp_pkg::mx_cmd_t              cmd,
  output modexp_pkg::mx_status_t           status,
  input  logic [modexp_pkg::WIDE_BITS-1:0] in_base_value,
  input  logic [modexp_pkg::WIDE_BITS-1:0] in_exponent,
  input  logic [MOD_BITS-1:0]              in_modulus,
  output logic [MOD_BITS-1:0]              out_power_result
);
  import modexp_pkg::*;

  localparam int T_W = MOD_BITS + 2;

  logic [MOD_BITS-1:0]  m_r, base_r, acc_r, rem_r, mcand_r, res_r;
  logic [MOD_BITS-1:0]  rem_nxt;
  logic [WIDE_BITS-1:0] exp_r, opnd_r;
  logic [CNT_W-1:0]     cnt_r;
  logic                 run_r, done_r, red_mode_r;
  logic [T_W-1:0]       addend, t_val, m1, m2;

  // One step: rem = (2*rem + addend) mod m, where addend < m so the sum stays below 3m.
  always_comb begin
    if (red_mode_r) begin
      addend = T_W'(opnd_r[WIDE_BITS-1]);
    end else begin
      addend = opnd_r[WIDE_BITS-1] ? T_W'(mcand_r) : '0;
    end
    t_val = {1'b0, rem_r, 1'b0} + addend;
    m1    = T_W'(m_r);
    m2    = {1'b0, m_r, 1'b0};
    if (t_val >= m2) begin
      rem_nxt = MOD_BITS'(t_val - m2);
    end else if (t_val >= m1) begin
      rem_nxt = MOD_BITS'(t_val - m1);
    end else begin
      rem_nxt = MOD_BITS'(t_val);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= run_r && (cnt_r == CNT_W'(1));
      if (cmd.op_start) begin
        run_r <= 1'b1;
      end else if (run_r && (cnt_r == CNT_W'(1))) begin
        run_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      m_r   <= in_modulus;
      exp_r <= in_exponent;
      acc_r <= MOD_BITS'(1);
    end
    if (cmd.op_start) begin
      rem_r <= '0;
      case (cmd.op)
        OP_REDUCE: begin
          red_mode_r <= 1'b1;
          opnd_r     <= in_base_value;
          mcand_r    <= '0;
          cnt_r      <= CNT_W'(WIDE_BITS);
        end
        OP_MUL: begin
          red_mode_r <= 1'b0;
          opnd_r     <= {base_r, {(WIDE_BITS-MOD_BITS){1'b0}}};
          mcand_r    <= acc_r;
          cnt_r      <= CNT_W'(MOD_BITS);
        end
        default: begin
          red_mode_r <= 1'b0;
          opnd_r     <= {base_r, {(WIDE_BITS-MOD_BITS){1'b0}}};
          mcand_r    <= base_r;
          cnt_r      <= CNT_W'(MOD_BITS);
        end
      endcase
    end else if (run_r) begin
      rem_r  <= rem_nxt;
      opnd_r <= {opnd_r[WIDE_BITS-2:0], 1'b0};
      cnt_r  <= cnt_r - CNT_W'(1);
    end
    if (cmd.wr_base) begin
      base_r <= rem_r;
    end
    if (cmd.wr_acc) begin
      acc_r <= rem_r;
    end
    if (cmd.shift_exp) begin
      exp_r <= {1'b0, exp_r[WIDE_BITS-1:1]};
    end
    if (cmd.emit) begin
      // moduli of zero or one answer 0
      res_r <= (m_r < MOD_BITS'(2)) ? '0 : acc_r;
    end
  end

  assign status.op_done  = done_r;
  assign status.exp_zero = (exp_r == '0);
  assign status.exp_lsb  = exp_r[0];
  assign status.exp_last = (exp_r[WIDE_BITS-1:1] == '0);

  assign out_power_result = res_r;

endmodule

FILE: rtl/core/modexp_ctrl.sv
// Sequencer for square-and-multiply over the exponent bits.
module modexp_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  output logic                   out_valid,
  output modexp_pkg::mx_cmd_t    cmd,
  input  modexp_pkg::mx_status_t status
);
  import modexp_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_REDUCE = 6'b000010,
    S_CHECK  = 6'b000100,
    S_MUL    = 6'b001000,
    S_SQR    = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.op    = OP_REDUCE;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load     = 1'b1;
          cmd.op_start = 1'b1;
          cmd.op       = OP_REDUCE;
          state_nxt    = S_REDUCE;
        end
      end
      S_REDUCE: begin
        if (status.op_done) begin
          cmd.wr_base = 1'b1;
          state_nxt   = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.exp_zero) begin
          state_nxt = S_DONE;
        end else if (status.exp_lsb) begin
          cmd.op_start = 1'b1;
          cmd.op       = OP_MUL;
          state_nxt    = S_MUL;
        end else begin
          cmd.op_start = 1'b1;
          cmd.op       = OP_SQR;
          state_nxt    = S_SQR;
        end
      end
      S_MUL: begin
        if (status.op_done) begin
          cmd.wr_acc = 1'b1;
          if (status.exp_last) begin
            // last set bit: the trailing square is never used
            state_nxt = S_DONE;
          end else begin
            cmd.op_start = 1'b1;
            cmd.op       = OP_SQR;
            state_nxt    = S_SQR;
          end
        end
      end
      S_SQR: begin
        if (status.op_done) begin
          cmd.wr_base   = 1'b1;
          cmd.shift_exp = 1'b1;
          state_nxt     = S_CHECK;
        end
      end
      S_DONE: begin
        cmd.emit  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= cmd.emit;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule
